// ----- src/cpc_pkg.sv -----
// ----------------------------------------------------------------------------
// Circle pair collision package
// Field widths, pipeline geometry, the item type and saturation helpers
// shared by the circle pair collision unit.
// ----------------------------------------------------------------------------
package cpc_pkg;

    localparam int POS_W      = 24;
    localparam int VEL_W      = 20;
    localparam int RAD_W      = 20;
    localparam int MASS_W     = 16;
    localparam int DX_W       = POS_W + 1;
    localparam int SQ_W       = 2 * DX_W;
    localparam int DIST_W     = DX_W;
    localparam int SQ_STAGES  = 25;
    localparam int LANES      = 6;
    localparam int VEL_LANES  = 4;
    localparam int LANE_PX    = 4;
    localparam int LANE_PY    = 5;
    localparam int LANE_W     = 48;
    localparam int DEN_W      = 26;
    localparam int Q_W        = 22;
    localparam int LAT        = 56;
    localparam int ONE_PIXEL  = 4096;

    typedef struct packed {
        logic signed [POS_W-1:0]  a_x;
        logic signed [POS_W-1:0]  a_y;
        logic signed [VEL_W-1:0]  a_vx;
        logic signed [VEL_W-1:0]  a_vy;
        logic        [RAD_W-1:0]  a_r;
        logic        [MASS_W-1:0] a_m;
        logic signed [POS_W-1:0]  b_x;
        logic signed [POS_W-1:0]  b_y;
        logic signed [VEL_W-1:0]  b_vx;
        logic signed [VEL_W-1:0]  b_vy;
        logic        [RAD_W-1:0]  b_r;
        logic        [MASS_W-1:0] b_m;
    } t_item;

    typedef struct packed {
        logic hit;
        logic nz;
    } t_hit;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [DX_W-1:0] v);
        if (v[DX_W-1] != v[POS_W-1]) begin
            return v[DX_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end
        return v[POS_W-1:0];
    endfunction

    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [DX_W-1:0] v);
        if (v[DX_W-1:VEL_W-1] != {(DX_W-VEL_W+1){v[DX_W-1]}}) begin
            return v[DX_W-1] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
        end
        return v[VEL_W-1:0];
    endfunction

endpackage

// ----- src/circle_pair_collision_unit.sv -----
// ----------------------------------------------------------------------------
// Circle pair collision unit
// Detects overlap of two circles, exchanges their velocities elastically with
// damping and pushes them apart along the centre line, in a 56 stage pipeline.
// ----------------------------------------------------------------------------
// Throughput is one item per cycle; busy is always low.
// The depth is set by the 25 stage square root followed by the multiply and
// the 22 stage quotient pipelines.
// Synchronous reset clears only the valid bits; results are never held off.
module circle_pair_collision_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [cpc_pkg::POS_W-1:0]    i_a_x_pos,
    input  logic signed [cpc_pkg::POS_W-1:0]    i_a_y_pos,
    input  logic signed [cpc_pkg::VEL_W-1:0]    i_a_vel_x,
    input  logic signed [cpc_pkg::VEL_W-1:0]    i_a_vel_y,
    input  logic        [cpc_pkg::RAD_W-1:0]    i_a_radius,
    input  logic        [cpc_pkg::MASS_W-1:0]   i_a_mass,
    input  logic signed [cpc_pkg::POS_W-1:0]    i_b_x_pos,
    input  logic signed [cpc_pkg::POS_W-1:0]    i_b_y_pos,
    input  logic signed [cpc_pkg::VEL_W-1:0]    i_b_vel_x,
    input  logic signed [cpc_pkg::VEL_W-1:0]    i_b_vel_y,
    input  logic        [cpc_pkg::RAD_W-1:0]    i_b_radius,
    input  logic        [cpc_pkg::MASS_W-1:0]   i_b_mass,
    output logic                                o_done,
    output logic                                o_collided,
    output logic signed [cpc_pkg::POS_W-1:0]    o_new_a_x,
    output logic signed [cpc_pkg::POS_W-1:0]    o_new_a_y,
    output logic signed [cpc_pkg::VEL_W-1:0]    o_new_a_vx,
    output logic signed [cpc_pkg::VEL_W-1:0]    o_new_a_vy,
    output logic signed [cpc_pkg::POS_W-1:0]    o_new_b_x,
    output logic signed [cpc_pkg::POS_W-1:0]    o_new_b_y,
    output logic signed [cpc_pkg::VEL_W-1:0]    o_new_b_vx,
    output logic signed [cpc_pkg::VEL_W-1:0]    o_new_b_vy
);

    localparam int NL = cpc_pkg::LANES;
    localparam int NV = cpc_pkg::VEL_LANES;
    localparam int NS = cpc_pkg::SQ_STAGES;
    localparam int NQ = cpc_pkg::Q_W;

    cpc_pkg::t_item in_item;

    logic [cpc_pkg::LAT-1:0] r_v;

    cpc_pkg::t_item r_it [0:54];

    logic signed [24:0] r_s1_dx, r_s1_dy, n_s1_dx, n_s1_dy;
    logic [48:0] r_s2_dx2, r_s2_dy2, n_s2_dx2, n_s2_dy2;
    logic [49:0] r_s3_d2, n_s3_d2;
    logic [49:0] r_sq_n [0:NS-1];
    logic [49:0] r_sq_r [0:NS-1];
    logic [49:0] n_sq_n [0:NS-1];
    logic [49:0] n_sq_r [0:NS-1];

    logic signed [24:0] r_p29_dx, r_p29_dy, n_p29_dx, n_p29_dy;
    logic [22:0] r_p29_ov, n_p29_ov;
    logic [24:0] r_p29_dist, n_p29_dist;
    cpc_pkg::t_hit r_hd [0:25];
    cpc_pkg::t_hit n_hd;
    logic signed [48:0] r_p30_px, r_p30_py, n_p30_px, n_p30_py;
    logic [24:0] r_p30_dist;

    logic signed [16:0] r_v27_dab, r_v27_dba, n_v27_dab, n_v27_dba;
    logic [16:0] r_v27_m2a, r_v27_m2b, r_v27_msum, n_v27_msum;
    logic signed [37:0] r_v28_p1 [0:NV-1];
    logic signed [37:0] r_v28_p2 [0:NV-1];
    logic signed [37:0] n_v28_p1 [0:NV-1];
    logic signed [37:0] n_v28_p2 [0:NV-1];
    logic [16:0] r_v28_msum;
    logic signed [38:0] r_v29_num [0:NV-1];
    logic signed [38:0] n_v29_num [0:NV-1];
    logic [20:0] r_v29_den, n_v29_den;
    logic signed [42:0] r_v30_n9 [0:NV-1];
    logic signed [42:0] n_v30_n9 [0:NV-1];
    logic [20:0] r_v30_den;

    logic        r_s31_neg [0:NL-1];
    logic [47:0] r_s31_mag [0:NL-1];
    logic        n_s31_neg [0:NL-1];
    logic [47:0] n_s31_mag [0:NL-1];
    logic [20:0] r_s31_vden;
    logic [24:0] r_s31_dist;

    logic        r_dm_neg [0:NL-1];
    logic [47:0] r_dm_mag [0:NL-1];
    logic [25:0] r_dm_den [0:NL-1];
    logic [47:0] n_dm_mag [0:NL-1];
    logic [25:0] n_dm_den [0:NL-1];

    logic [47:0] r_dv_rem [0:NQ-1][0:NL-1];
    logic [21:0] r_dv_q   [0:NQ-1][0:NL-1];
    logic [25:0] r_dv_den [0:NQ-1][0:NL-1];
    logic        r_dv_neg [0:NQ-1][0:NL-1];
    logic [47:0] n_dv_rem [0:NQ-1][0:NL-1];
    logic [21:0] n_dv_q   [0:NQ-1][0:NL-1];

    logic                          n_col;
    logic signed [cpc_pkg::POS_W-1:0] n_nax, n_nay, n_nbx, n_nby;
    logic signed [cpc_pkg::VEL_W-1:0] n_navx, n_navy, n_nbvx, n_nbvy;
    logic                          r_col;
    logic signed [cpc_pkg::POS_W-1:0] r_nax, r_nay, r_nbx, r_nby;
    logic signed [cpc_pkg::VEL_W-1:0] r_navx, r_navy, r_nbvx, r_nbvy;

    assign in_item = '{a_x: i_a_x_pos, a_y: i_a_y_pos, a_vx: i_a_vel_x, a_vy: i_a_vel_y,
                       a_r: i_a_radius, a_m: i_a_mass, b_x: i_b_x_pos, b_y: i_b_y_pos,
                       b_vx: i_b_vel_x, b_vy: i_b_vel_y, b_r: i_b_radius, b_m: i_b_mass};

    assign busy = 1'b0;

    always_comb begin
        logic [49:0] sq_bit, sq_t, sq_nin, sq_rin;
        logic [20:0] rs;
        logic signed [26:0] thr, d27, ov27;
        logic [16:0] msum;
        logic signed [16:0] coef [0:NV-1];
        logic [16:0] m2 [0:NV-1];
        logic signed [19:0] vs [0:NV-1];
        logic signed [19:0] vo [0:NV-1];
        logic signed [42:0] ne, na;
        logic signed [48:0] pa;
        logic [47:0] dv_sh, rin;
        logic [21:0] qin;
        logic signed [22:0] sq [0:NL-1];
        logic signed [24:0] se [0:NL-1];
        logic signed [24:0] ax, ay, bx, by;
        cpc_pkg::t_item it;

        n_s1_dx = $signed({r_it[0].b_x[23], r_it[0].b_x}) - $signed({r_it[0].a_x[23], r_it[0].a_x});
        n_s1_dy = $signed({r_it[0].b_y[23], r_it[0].b_y}) - $signed({r_it[0].a_y[23], r_it[0].a_y});
        n_s2_dx2 = 49'(r_s1_dx * r_s1_dx);
        n_s2_dy2 = 49'(r_s1_dy * r_s1_dy);
        n_s3_d2 = {1'b0, r_s2_dx2} + {1'b0, r_s2_dy2};

        for (int j = 0; j < NS; j++) begin
            sq_bit = 50'(1) << (2 * (NS - 1 - j));
            sq_nin = (j == 0) ? r_s3_d2 : r_sq_n[(j == 0) ? 0 : j - 1];
            sq_rin = (j == 0) ? 50'(0) : r_sq_r[(j == 0) ? 0 : j - 1];
            sq_t = sq_rin | sq_bit;
            if (sq_nin >= sq_t) begin
                n_sq_n[j] = sq_nin - sq_t;
                n_sq_r[j] = (sq_rin >> 1) + sq_bit;
            end else begin
                n_sq_n[j] = sq_nin;
                n_sq_r[j] = sq_rin >> 1;
            end
        end

        it = r_it[28];
        rs = {1'b0, it.a_r} + {1'b0, it.b_r};
        d27 = $signed({2'b0, r_sq_r[NS-1][24:0]});
        thr = $signed({6'b0, rs}) - 27'sd4096;
        ov27 = $signed({6'b0, rs}) - d27 + 27'sd4096;
        n_hd.hit = d27 < thr;
        n_hd.nz = r_sq_r[NS-1][24:0] != 25'd0;
        n_p29_ov = ov27[22:0];
        n_p29_dist = r_sq_r[NS-1][24:0];
        n_p29_dx = $signed({it.b_x[23], it.b_x}) - $signed({it.a_x[23], it.a_x});
        n_p29_dy = $signed({it.b_y[23], it.b_y}) - $signed({it.a_y[23], it.a_y});
        n_p30_px = 49'(r_p29_dx * $signed({1'b0, r_p29_ov}));
        n_p30_py = 49'(r_p29_dy * $signed({1'b0, r_p29_ov}));

        it = r_it[26];
        msum = {1'b0, it.a_m} + {1'b0, it.b_m};
        if (msum == 17'd0) begin
            n_v27_dab = 17'sd1;
            n_v27_dba = 17'sd1;
            n_v27_msum = 17'd1;
        end else begin
            n_v27_dab = $signed({1'b0, it.a_m}) - $signed({1'b0, it.b_m});
            n_v27_dba = $signed({1'b0, it.b_m}) - $signed({1'b0, it.a_m});
            n_v27_msum = msum;
        end

        it = r_it[27];
        coef[0] = r_v27_dab;  m2[0] = r_v27_m2b;  vs[0] = it.a_vx;  vo[0] = it.b_vx;
        coef[1] = r_v27_dab;  m2[1] = r_v27_m2b;  vs[1] = it.a_vy;  vo[1] = it.b_vy;
        coef[2] = r_v27_dba;  m2[2] = r_v27_m2a;  vs[2] = it.b_vx;  vo[2] = it.a_vx;
        coef[3] = r_v27_dba;  m2[3] = r_v27_m2a;  vs[3] = it.b_vy;  vo[3] = it.a_vy;
        for (int l = 0; l < NV; l++) begin
            n_v28_p1[l] = 38'(coef[l] * vs[l]);
            n_v28_p2[l] = 38'($signed({1'b0, m2[l]}) * vo[l]);
            n_v29_num[l] = 39'(r_v28_p1[l]) + 39'(r_v28_p2[l]);
            ne = 43'(r_v29_num[l]);
            n_v30_n9[l] = (ne <<< 3) + ne;
            n_s31_neg[l] = r_v30_n9[l][42];
            na = r_v30_n9[l][42] ? -r_v30_n9[l] : r_v30_n9[l];
            n_s31_mag[l] = {6'b0, na[41:0]};
            n_dm_mag[l] = r_s31_mag[l] + {28'b0, r_s31_vden[20:1]};
            n_dm_den[l] = {5'b0, r_s31_vden};
        end
        n_v29_den = {1'b0, r_v28_msum, 3'b0} + {3'b0, r_v28_msum, 1'b0};

        n_s31_neg[cpc_pkg::LANE_PX] = r_p30_px[48];
        pa = r_p30_px[48] ? -r_p30_px : r_p30_px;
        n_s31_mag[cpc_pkg::LANE_PX] = pa[47:0];
        n_s31_neg[cpc_pkg::LANE_PY] = r_p30_py[48];
        pa = r_p30_py[48] ? -r_p30_py : r_p30_py;
        n_s31_mag[cpc_pkg::LANE_PY] = pa[47:0];
        for (int l = NV; l < NL; l++) begin
            n_dm_mag[l] = r_s31_mag[l] + {23'b0, r_s31_dist};
            n_dm_den[l] = {r_s31_dist, 1'b0};
        end

        for (int i = 0; i < NQ; i++) begin
            for (int l = 0; l < NL; l++) begin
                if (i == 0) begin
                    rin = r_dm_mag[l];
                    qin = 22'd0;
                    dv_sh = {22'b0, r_dm_den[l]} << (NQ - 1 - i);
                end else begin
                    rin = r_dv_rem[(i == 0) ? 0 : i - 1][l];
                    qin = r_dv_q[(i == 0) ? 0 : i - 1][l];
                    dv_sh = {22'b0, r_dv_den[(i == 0) ? 0 : i - 1][l]} << (NQ - 1 - i);
                end
                if (rin >= dv_sh) begin
                    n_dv_rem[i][l] = rin - dv_sh;
                    n_dv_q[i][l] = qin | (22'd1 << (NQ - 1 - i));
                end else begin
                    n_dv_rem[i][l] = rin;
                    n_dv_q[i][l] = qin;
                end
            end
        end

        for (int l = 0; l < NL; l++) begin
            sq[l] = r_dv_neg[NQ-1][l] ? -$signed({1'b0, r_dv_q[NQ-1][l]})
                                      : $signed({1'b0, r_dv_q[NQ-1][l]});
            se[l] = 25'(sq[l]);
        end

        it = r_it[54];
        ax = 25'(it.a_x);
        ay = 25'(it.a_y);
        bx = 25'(it.b_x);
        by = 25'(it.b_y);
        n_col = r_hd[25].hit;
        n_nax = it.a_x;
        n_nay = it.a_y;
        n_nbx = it.b_x;
        n_nby = it.b_y;
        n_navx = it.a_vx;
        n_navy = it.a_vy;
        n_nbvx = it.b_vx;
        n_nbvy = it.b_vy;
        if (r_hd[25].hit) begin
            n_navx = cpc_pkg::sat_vel(se[0]);
            n_navy = cpc_pkg::sat_vel(se[1]);
            n_nbvx = cpc_pkg::sat_vel(se[2]);
            n_nbvy = cpc_pkg::sat_vel(se[3]);
            if (r_hd[25].nz) begin
                n_nax = cpc_pkg::sat_pos(ax - se[cpc_pkg::LANE_PX]);
                n_nay = cpc_pkg::sat_pos(ay - se[cpc_pkg::LANE_PY]);
                n_nbx = cpc_pkg::sat_pos(bx + se[cpc_pkg::LANE_PX]);
                n_nby = cpc_pkg::sat_pos(by + se[cpc_pkg::LANE_PY]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[cpc_pkg::LAT-2:0], start & ~busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_it[0] <= in_item;
        for (int k = 1; k < 55; k++) begin
            r_it[k] <= r_it[k-1];
        end
        r_s1_dx <= n_s1_dx;
        r_s1_dy <= n_s1_dy;
        r_s2_dx2 <= n_s2_dx2;
        r_s2_dy2 <= n_s2_dy2;
        r_s3_d2 <= n_s3_d2;
        r_sq_n <= n_sq_n;
        r_sq_r <= n_sq_r;
        r_p29_dx <= n_p29_dx;
        r_p29_dy <= n_p29_dy;
        r_p29_ov <= n_p29_ov;
        r_p29_dist <= n_p29_dist;
        r_hd[0] <= n_hd;
        for (int k = 1; k < 26; k++) begin
            r_hd[k] <= r_hd[k-1];
        end
        r_p30_px <= n_p30_px;
        r_p30_py <= n_p30_py;
        r_p30_dist <= r_p29_dist;
        r_v27_dab <= n_v27_dab;
        r_v27_dba <= n_v27_dba;
        r_v27_m2a <= {r_it[26].a_m, 1'b0};
        r_v27_m2b <= {r_it[26].b_m, 1'b0};
        r_v27_msum <= n_v27_msum;
        r_v28_p1 <= n_v28_p1;
        r_v28_p2 <= n_v28_p2;
        r_v28_msum <= r_v27_msum;
        r_v29_num <= n_v29_num;
        r_v29_den <= n_v29_den;
        r_v30_n9 <= n_v30_n9;
        r_v30_den <= r_v29_den;
        r_s31_neg <= n_s31_neg;
        r_s31_mag <= n_s31_mag;
        r_s31_vden <= r_v30_den;
        r_s31_dist <= r_p30_dist;
        r_dm_neg <= r_s31_neg;
        r_dm_mag <= n_dm_mag;
        r_dm_den <= n_dm_den;
        for (int i = 0; i < NQ; i++) begin
            for (int l = 0; l < NL; l++) begin
                r_dv_rem[i][l] <= n_dv_rem[i][l];
                r_dv_q[i][l] <= n_dv_q[i][l];
                if (i == 0) begin
                    r_dv_den[i][l] <= r_dm_den[l];
                    r_dv_neg[i][l] <= r_dm_neg[l];
                end else begin
                    r_dv_den[i][l] <= r_dv_den[(i == 0) ? 0 : i - 1][l];
                    r_dv_neg[i][l] <= r_dv_neg[(i == 0) ? 0 : i - 1][l];
                end
            end
        end
        r_col <= n_col;
        r_nax <= n_nax;
        r_nay <= n_nay;
        r_nbx <= n_nbx;
        r_nby <= n_nby;
        r_navx <= n_navx;
        r_navy <= n_navy;
        r_nbvx <= n_nbvx;
        r_nbvy <= n_nbvy;
    end

    assign o_done     = r_v[cpc_pkg::LAT-1];
    assign o_collided = r_col;
    assign o_new_a_x  = r_nax;
    assign o_new_a_y  = r_nay;
    assign o_new_a_vx = r_navx;
    assign o_new_a_vy = r_navy;
    assign o_new_b_x  = r_nbx;
    assign o_new_b_y  = r_nby;
    assign o_new_b_vx = r_nbvx;
    assign o_new_b_vy = r_nbvy;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##(cpc_pkg::LAT) o_done)
        else $error("An accepted item did not produce a result on time.");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, cpc_pkg::LAT))
        else $error("A result appeared without an accepted item.");

    a_pass_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_collided) |-> (o_new_a_x == $past(i_a_x_pos, cpc_pkg::LAT) &&
                                     o_new_b_vy == $past(i_b_vel_y, cpc_pkg::LAT)))
        else $error("A pair without collision did not pass through unchanged.");

endmodule

// ----- sim/circle_pair_collision_unit_test.sv -----
// ----------------------------------------------------------------------------
// Circle pair collision unit regression
// Drives directed and random circle pairs through the unit with random
// sender gaps, predicts every result in the testbench and compares each
// strobed result as a whole against the oldest prediction.
// ----------------------------------------------------------------------------
module circle_pair_collision_unit_test;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = cpc_pkg::LAT + 8;

    typedef struct packed {
        logic                              collided;
        logic signed [cpc_pkg::POS_W-1:0]  a_x;
        logic signed [cpc_pkg::POS_W-1:0]  a_y;
        logic signed [cpc_pkg::VEL_W-1:0]  a_vx;
        logic signed [cpc_pkg::VEL_W-1:0]  a_vy;
        logic signed [cpc_pkg::POS_W-1:0]  b_x;
        logic signed [cpc_pkg::POS_W-1:0]  b_y;
        logic signed [cpc_pkg::VEL_W-1:0]  b_vx;
        logic signed [cpc_pkg::VEL_W-1:0]  b_vy;
    } t_outcome;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    cpc_pkg::t_item drive = '0;
    logic  o_done;
    t_outcome got;

    t_outcome pending_results[$];
    int       mismatches = 0;
    int       quiet_cycles = 0;
    int       gap_percent = 0;

    circle_pair_collision_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_a_x_pos  (drive.a_x),
        .i_a_y_pos  (drive.a_y),
        .i_a_vel_x  (drive.a_vx),
        .i_a_vel_y  (drive.a_vy),
        .i_a_radius (drive.a_r),
        .i_a_mass   (drive.a_m),
        .i_b_x_pos  (drive.b_x),
        .i_b_y_pos  (drive.b_y),
        .i_b_vel_x  (drive.b_vx),
        .i_b_vel_y  (drive.b_vy),
        .i_b_radius (drive.b_r),
        .i_b_mass   (drive.b_m),
        .o_done     (o_done),
        .o_collided (got.collided),
        .o_new_a_x  (got.a_x),
        .o_new_a_y  (got.a_y),
        .o_new_a_vx (got.a_vx),
        .o_new_a_vy (got.a_vy),
        .o_new_b_x  (got.b_x),
        .o_new_b_y  (got.b_y),
        .o_new_b_vx (got.b_vx),
        .o_new_b_vy (got.b_vy)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint clamp(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = num < 0 ? -num : num;
        q = (mag + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned r = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint damped_exchange(longint m_self, longint m_other,
                                               longint v_self, longint v_other);
        longint total;
        total = m_self + m_other;
        if (total == 0) begin
            return round_div(9 * v_self, 10);
        end
        return round_div(9 * ((m_self - m_other) * v_self + 2 * m_other * v_other),
                         10 * total);
    endfunction

    function automatic t_outcome predict_collision(cpc_pkg::t_item it);
        t_outcome res;
        longint ax, ay, bx, by, ar, br, am, bm, dx, dy, span, ov, px, py;
        longint nax, nay, nbx, nby, navx, navy, nbvx, nbvy;
        ax = it.a_x; ay = it.a_y; bx = it.b_x; by = it.b_y;
        ar = it.a_r; br = it.b_r; am = it.a_m; bm = it.b_m;
        dx = bx - ax;
        dy = by - ay;
        span = longint'(root_floor(longint'(dx * dx + dy * dy)));
        nax = ax; nay = ay; nbx = bx; nby = by;
        navx = it.a_vx; navy = it.a_vy; nbvx = it.b_vx; nbvy = it.b_vy;
        res.collided = span < ar + br - cpc_pkg::ONE_PIXEL;
        if (res.collided) begin
            navx = damped_exchange(am, bm, it.a_vx, it.b_vx);
            navy = damped_exchange(am, bm, it.a_vy, it.b_vy);
            nbvx = damped_exchange(bm, am, it.b_vx, it.a_vx);
            nbvy = damped_exchange(bm, am, it.b_vy, it.a_vy);
            if (span > 0) begin
                ov = ar + br - span + cpc_pkg::ONE_PIXEL;
                px = round_div(dx * ov, 2 * span);
                py = round_div(dy * ov, 2 * span);
                nax = ax - px;
                nay = ay - py;
                nbx = bx + px;
                nby = by + py;
            end
        end
        res.a_x  = clamp(nax, cpc_pkg::POS_W);
        res.a_y  = clamp(nay, cpc_pkg::POS_W);
        res.a_vx = clamp(navx, cpc_pkg::VEL_W);
        res.a_vy = clamp(navy, cpc_pkg::VEL_W);
        res.b_x  = clamp(nbx, cpc_pkg::POS_W);
        res.b_y  = clamp(nby, cpc_pkg::POS_W);
        res.b_vx = clamp(nbvx, cpc_pkg::VEL_W);
        res.b_vy = clamp(nbvy, cpc_pkg::VEL_W);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n) begin
            quiet_cycles <= (o_done || (start && !busy)) ? 0 : quiet_cycles + 1;
            if (o_done) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected result %h.", got);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Mismatch: expected %h, got %h.", want, got);
                        end
                    end
                end
            end
            if (start && !busy) pending_results.push_back(predict_collision(drive));
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("circle_pair_collision_unit regression: fail");
            $finish;
        end
    end

    task automatic send_item(cpc_pkg::t_item it);
        drive <= it;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        while ($urandom_range(99) < gap_percent) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic cpc_pkg::t_item random_pair(bit close);
        cpc_pkg::t_item it;
        logic [255:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(cpc_pkg::t_item)-1:0];
        if (close) begin
            it.b_x = 24'(it.a_x + $signed($urandom_range(0, 2 ** 22)) - 2 ** 21);
            it.b_y = 24'(it.a_y + $signed($urandom_range(0, 2 ** 22)) - 2 ** 21);
            if ($urandom_range(9) == 0) it.b_y = it.a_y;
            if ($urandom_range(19) == 0) it.b_x = it.a_x;
        end
        if ($urandom_range(15) == 0) it.a_m = '0;
        if ($urandom_range(15) == 0) it.b_m = '0;
        if ($urandom_range(31) == 0) it.a_r = '0;
        return it;
    endfunction

    task automatic test_directed();
        cpc_pkg::t_item it;
        it = '0;
        send_item(it);
        it = '{a_x: 0, a_y: 0, a_vx: 4096, a_vy: 0, a_r: 40960, a_m: 256,
               b_x: 49152, b_y: 0, b_vx: -4096, b_vy: 0, b_r: 40960, b_m: 256};
        send_item(it);
        it.b_m = 1024;
        it.b_y = 20480;
        send_item(it);
        it.b_x = 0;
        it.b_y = 0;
        send_item(it);
        it.a_m = 0;
        it.b_m = 0;
        send_item(it);
        it.b_x = 49152;
        send_item(it);
        it.a_r = 0;
        it.b_r = 0;
        send_item(it);
        it.a_r = 20'hFFFFF;
        it.b_r = 20'hFFFFF;
        it.a_m = 16'hFFFF;
        it.b_m = 1;
        it.a_vx = 20'h7FFFF;
        it.b_vx = 20'h80000;
        it.a_vy = 20'h80000;
        it.b_vy = 20'h7FFFF;
        send_item(it);
        it.a_x = 24'h7FFFF0;
        it.b_x = 24'h800010;
        send_item(it);
        it.a_x = 24'h800000;
        it.a_y = 24'h800000;
        it.b_x = 24'h800000 + 4096;
        it.b_y = 24'h800000 + 4096;
        send_item(it);
        it.a_x = 24'h7FFFFF;
        it.a_y = 24'h7FFFFF;
        it.b_x = 24'h7FFFFF - 4096;
        it.b_y = 24'h7FFFFF;
        send_item(it);
        it.a_m = 16'hFFFF;
        it.b_m = 16'hFFFF;
        send_item(it);
        it = '{a_x: 24'h800000, a_y: 24'h7FFFFF, a_vx: 20'h80000, a_vy: 20'h7FFFF,
               a_r: 20'hFFFFF, a_m: 16'hFFFF, b_x: 24'h7FFFFF, b_y: 24'h800000,
               b_vx: 20'h7FFFF, b_vy: 20'h80000, b_r: 20'hFFFFF, b_m: 16'hFFFF};
        send_item(it);
        it.a_r = 1;
        it.b_r = 4095;
        it.b_x = it.a_x;
        it.b_y = it.a_y;
        send_item(it);
        it.b_r = 4097;
        send_item(it);
    endtask

    task automatic test_random(int count, int gaps);
        gap_percent = gaps;
        repeat (count) send_item(random_pair($urandom_range(99) < 75));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        wait_drained();
        test_random(630, 28);
        wait_drained();
        test_random(630, 81);
        test_random(640, 0);
        wait_drained();
        start <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("circle_pair_collision_unit regression: pass");
        end else begin
            $display("circle_pair_collision_unit regression: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/cpc_pkg.sv
src/circle_pair_collision_unit.sv
sim/circle_pair_collision_unit_test.sv
